### hdl/imc_pkg.sv
// Package for the 2-D image convolution block: shared types and constants
// No dependencies
package imc_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxKernelDef = 5;
  localparam int unsigned CoefBitsDef  = 12;
  localparam int unsigned FracBitsDef  = 8;
  localparam int unsigned PixBits      = 16;
  localparam int unsigned NumRegs      = 8;
  localparam int unsigned RegIdxBits   = 3;
  localparam int unsigned RegBits      = 60;

  typedef enum logic [RegIdxBits-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KSIZE  = 3'd2,
    REG_COEF0  = 3'd3,
    REG_COEF1  = 3'd4,
    REG_COEF2  = 3'd5,
    REG_COEF3  = 3'd6,
    REG_COEF4  = 3'd7
  } reg_idx_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  // one classified work item handed from front to back
  typedef struct packed {
    logic                do_push;
    logic [PixBits-1:0]  pix;
    logic [12:0]         col;
    logic                do_emit;
    logic                border;
    logic                last;
  } work_t;

endpackage

### hdl/imc_front.sv
// Front part of the image convolution: takes transfers, tracks raster counters
// and classifies each item into push / emit work. Depends on imc_pkg.
module imc_front
  import imc_pkg::*;
#(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxKernel = MaxKernelDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                restart_i,
  input  logic [10:0]         width_i,
  input  logic [15:0]         height_i,
  input  logic [2:0]          ksize_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [PixBits-1:0]  pix_i,
  output logic                wk_valid_o,
  input  logic                wk_ready_i,
  output work_t               wk_o,
  output logic [2:0]          khalf_o
);

  localparam int unsigned ColBits = 13;

  logic [ColBits-1:0] w_eff;
  logic [15:0]        h_eff;
  logic [2:0]         k_eff, hk;
  logic [ColBits-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [15:0]        in_row_q, in_row_d, out_row_q, out_row_d;
  logic               in_done_q, in_done_d;
  // column of the virtual input position (out position plus delay) that a flush item fills
  logic [ColBits-1:0] vcol;
  logic               lag_ok, out_pend, border, last, acc, emit;

  // effective geometry
  always_comb begin
    w_eff = {2'b0, width_i};
    if (width_i == '0) w_eff = ColBits'(1);
    if (32'(w_eff) > MaxWidth) w_eff = ColBits'(MaxWidth);
    h_eff = (height_i == '0) ? 16'd1 : height_i;
    k_eff = ksize_i;
    if (k_eff < 3'd3) k_eff = 3'd3;
    if (k_eff > 3'(MaxKernel)) k_eff = 3'(MaxKernel);
    if (!k_eff[0]) k_eff = k_eff - 3'd1;
    hk = k_eff >> 1;
  end
  assign khalf_o = hk;

  // n >= m + h*W + h, done by comparing rows then columns
  always_comb begin
    logic [16:0] rdiff;
    logic [ColBits:0] csum;
    rdiff = {1'b0, in_row_q} - {1'b0, out_row_q};
    csum  = {1'b0, out_col_q} + (ColBits+1)'(hk);
    // position out+delay = row out_row+hk+carry, col csum mod w
    if (csum >= ({1'b0, w_eff} << 1)) begin
      // one-pixel rows: the column offset wraps twice
      lag_ok = (rdiff > 17'(hk) + 17'd2) ||
               ((rdiff == 17'(hk) + 17'd2) &&
                ({1'b0, in_col_q} >= csum - ({1'b0, w_eff} << 1)));
      vcol = ColBits'(csum - ({1'b0, w_eff} << 1));
    end else if (csum >= {1'b0, w_eff}) begin
      lag_ok = (rdiff > 17'(hk) + 17'd1) ||
               ((rdiff == 17'(hk) + 17'd1) &&
                ({1'b0, in_col_q} >= csum - {1'b0, w_eff}));
      vcol = ColBits'(csum - {1'b0, w_eff});
    end else begin
      lag_ok = (rdiff > 17'(hk)) ||
               ((rdiff == 17'(hk)) && ({1'b0, in_col_q} >= csum));
      vcol = ColBits'(csum);
    end
    if (rdiff[16]) lag_ok = 1'b0;
  end

  assign out_pend = 1'b1;
  assign border = (out_row_q < 16'(hk)) || ({1'b0, out_row_q} + 17'(hk) >= {1'b0, h_eff})
               || (out_col_q < ColBits'(hk))
               || ({1'b0, out_col_q} + (ColBits+1)'(hk) >= {1'b0, w_eff});
  assign last = ({1'b0, out_row_q} + 17'd1 >= {1'b0, h_eff})
             && ({1'b0, out_col_q} + (ColBits+1)'(1) >= {1'b0, w_eff});

  assign in_ready_o = wk_ready_i;
  assign acc = in_valid_i && in_ready_o;

  // classify and advance counters
  always_comb begin
    in_col_d = in_col_q; in_row_d = in_row_q; in_done_d = in_done_q;
    out_col_d = out_col_q; out_row_d = out_row_q;
    wk_o = '0;
    wk_o.pix = pix_i;
    wk_o.border = border;
    wk_o.last = last;
    emit = 1'b0;
    if (kind_i == KIND_PIXEL) begin
      if (!in_done_q) begin
        wk_o.do_push = 1'b1;
        wk_o.col = in_col_q;
        emit = lag_ok;
        if (in_col_q + ColBits'(1) >= w_eff) begin
          in_col_d = '0;
          in_row_d = in_row_q + 16'd1;
          if (in_row_q + 16'd1 >= h_eff) in_done_d = 1'b1;
        end else begin
          in_col_d = in_col_q + ColBits'(1);
        end
      end
    end else if (in_done_q && out_pend) begin
      wk_o.do_push = 1'b1;
      wk_o.pix = '0;
      wk_o.col = vcol;
      emit = 1'b1;
    end
    wk_o.do_emit = emit;
    if (emit) begin
      if (last) begin
        in_col_d = '0; in_row_d = '0; out_col_d = '0; out_row_d = '0;
        in_done_d = 1'b0;
      end else if (out_col_q + ColBits'(1) >= w_eff) begin
        out_col_d = '0; out_row_d = out_row_q + 16'd1;
      end else begin
        out_col_d = out_col_q + ColBits'(1);
      end
    end
  end

  assign wk_valid_o = in_valid_i && (wk_o.do_push || wk_o.do_emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0; in_row_q <= '0; out_col_q <= '0; out_row_q <= '0;
      in_done_q <= 1'b0;
    end else if (restart_i) begin
      in_col_q <= '0; in_row_q <= '0; out_col_q <= '0; out_row_q <= '0;
      in_done_q <= 1'b0;
    end else if (acc) begin
      in_col_q <= in_col_d; in_row_q <= in_row_d; in_done_q <= in_done_d;
      out_col_q <= out_col_d; out_row_q <= out_row_d;
    end
  end

endmodule

### hdl/imc_queue.sv
// Short two-entry queue between front and back of the image convolution
// Depends on imc_pkg
module imc_queue
  import imc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  work_t wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output work_t rd_data_o
);

  work_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

### hdl/imc_back.sv
// Back part of the image convolution: line stores, window, multiply tree,
// rounding, saturation and output register. Depends on imc_pkg.
module imc_back
  import imc_pkg::*;
#(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxKernel = MaxKernelDef,
  parameter int unsigned CoefBits  = CoefBitsDef,
  parameter int unsigned FracBits  = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          khalf_i,
  input  logic [RegBits-1:0]  coef_i [5],
  input  logic                wk_valid_i,
  output logic                wk_ready_o,
  input  work_t               wk_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixBits-1:0]  pix_o,
  output logic                border_o,
  output logic                sat_o,
  output logic                last_o
);

  localparam int unsigned Lines  = MaxKernel - 1;
  localparam int unsigned AddrW  = $clog2(MaxWidth);
  localparam int unsigned ProdW  = PixBits + CoefBits;
  localparam int unsigned AccW   = ProdW + 6;
  localparam int unsigned NTap   = MaxKernel * MaxKernel;

  // stage 1: line store read
  logic [PixBits-1:0] lmem [Lines][MaxWidth];
  logic [PixBits-1:0] lrd_q [Lines];
  logic               s1_v_q, s2_v_q;
  work_t              s1_q, s2_q;
  logic               adv;
  logic [AddrW-1:0]   addr;
  logic [AddrW-1:0]   s1_addr_q;
  logic [PixBits-1:0] col_v [MaxKernel];
  logic signed [PixBits-1:0] win_q [MaxKernel][MaxKernel];
  logic signed [PixBits-1:0] win_n [MaxKernel][MaxKernel];
  logic signed [ProdW-1:0]   prod_q [NTap];
  logic signed [AccW-1:0]    acc;
  logic signed [AccW-1:0]    tsum, val;
  logic [2:0] k_m1;
  logic               o_v_q;
  logic [PixBits-1:0] o_pix_q;
  logic               o_b_q, o_s_q, o_l_q;
  logic               s1_push;

  // whole pipeline stalls together when the output register is held
  assign adv = !o_v_q || out_ready_i;
  assign wk_ready_o = adv;
  assign addr = (32'(wk_i.col) >= MaxWidth) ? AddrW'(MaxWidth - 1) : AddrW'(wk_i.col);
  assign k_m1 = {khalf_i[1:0], 1'b0};
  assign s1_push = s1_v_q && s1_q.do_push;

  // line store memory, read registered; write-back of shifted column,
  // forwarded when the next item reads the column being written
  always_ff @(posedge clk_i) begin
    if (adv && wk_valid_i && wk_i.do_push) begin
      for (int i = 0; i < Lines; i++) begin
        if (s1_push && s1_addr_q == addr && 3'(i) < k_m1) lrd_q[i] <= col_v[i];
        else lrd_q[i] <= lmem[i][addr];
      end
    end
    if (adv && s1_push) begin
      for (int i = 0; i < Lines; i++) begin
        if (3'(i) < k_m1) lmem[i][s1_addr_q] <= col_v[i];
      end
    end
  end

  // fresh column: new pixel then stored lines
  always_comb begin
    col_v[0] = s1_q.pix;
    for (int i = 1; i < MaxKernel; i++) col_v[i] = lrd_q[i-1];
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= wk_valid_i; s2_v_q <= s1_v_q && s1_q.do_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= wk_i; s1_addr_q <= addr;
      s2_q <= s1_q;
    end
  end

  // window after the column of the stage 1 item has been shifted in
  always_comb begin
    win_n = win_q;
    if (s1_push) begin
      for (int i = 0; i < MaxKernel; i++) begin
        for (int j = MaxKernel - 1; j > 0; j--) win_n[i][j] = win_q[i][j-1];
        win_n[i][0] = col_v[i];
      end
    end
  end

  // window register; taps beyond the kernel just hold don't-care data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxKernel; i++)
        for (int j = 0; j < MaxKernel; j++) win_q[i][j] <= '0;
    end else if (adv) begin
      for (int i = 0; i < MaxKernel; i++)
        for (int j = 0; j < MaxKernel; j++) win_q[i][j] <= win_n[i][j];
    end
  end

  // stage 2: products; coefficient (r,c) meets window (k-1-r, k-1-c)
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < MaxKernel; r++) begin
        for (int c = 0; c < MaxKernel; c++) begin
          logic signed [CoefBits-1:0] cf;
          logic [2:0] wr, wc;
          cf = '0;
          if (r < 5 && (c + 1) * CoefBits <= RegBits)
            cf = coef_i[r % 5][(c * CoefBits) % RegBits +: CoefBits];
          wr = k_m1 - 3'(r);
          wc = k_m1 - 3'(c);
          if (3'(r) > k_m1 || 3'(c) > k_m1) prod_q[r*MaxKernel+c] <= '0;
          else prod_q[r*MaxKernel+c] <= cf * win_n[wr][wc];
        end
      end
    end
  end

  logic [PixBits-1:0] cen2_q;
  always_ff @(posedge clk_i) begin
    if (adv) cen2_q <= win_n[khalf_i][khalf_i];
  end

  // stage 3: adder tree, round and saturate
  always_comb begin
    acc = '0;
    for (int t = 0; t < NTap; t++) acc = acc + AccW'(prod_q[t]);
    tsum = acc + AccW'(1 << (FracBits - 1));
    val  = tsum >>> FracBits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_v_q <= 1'b0;
    else if (adv) o_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_v_q) begin
      o_b_q <= s2_q.border; o_l_q <= s2_q.last;
      o_s_q <= 1'b0;
      if (s2_q.border) o_pix_q <= cen2_q;
      else if (val > AccW'(32767)) begin o_pix_q <= 16'h7fff; o_s_q <= 1'b1; end
      else if (val < -AccW'(32768)) begin o_pix_q <= 16'h8000; o_s_q <= 1'b1; end
      else o_pix_q <= val[PixBits-1:0];
    end
  end

  assign out_valid_o = o_v_q;
  assign pix_o = o_pix_q;
  assign border_o = o_b_q;
  assign sat_o = o_s_q;
  assign last_o = o_l_q;

endmodule

### hdl/image_convolution_2d.sv
// Top level of the 2-D image convolution (3x3 / 5x5 kernel)
// One item per cycle sustained while the output is not held, carried by the line store's
// separate read and write and by the fully parallel multiply tree.
// Reset clears counters, window and registers to defaults; line store is not cleared.
// Depends on imc_pkg, imc_front, imc_queue, imc_back.
module image_convolution_2d
  import imc_pkg::*;
#(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxKernel = MaxKernelDef,
  parameter int unsigned CoefBits  = CoefBitsDef,
  parameter int unsigned FracBits  = FracBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RegIdxBits-1:0] cfg_idx_i,
  input  logic [RegBits-1:0]    cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // pixel_in
  input  logic                  s_axis_tuser,  // kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,  // pixel_out
  output logic [1:0]            m_axis_tuser,  // is_border, saturated
  output logic                  m_axis_tlast   // end_of_frame
);

  logic [10:0]        width_q;
  logic [15:0]        height_q;
  logic [2:0]         ksize_q;
  logic [RegBits-1:0] coef_q [5];
  logic               restart;
  logic [2:0]         khalf;
  logic               fv, fr, bv, br;
  work_t              fw, bw;
  logic [PixBits-1:0] pix;
  logic               bd, st, ls;

  // configuration registers
  assign restart = cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT
                                || cfg_idx_i == REG_KSIZE);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 11'd640; height_q <= 16'd480; ksize_q <= 3'd3;
      for (int i = 0; i < 5; i++) coef_q[i] <= (i == 2) ? RegBits'(256) : '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:  width_q <= cfg_data_i[10:0];
        REG_HEIGHT: height_q <= cfg_data_i[15:0];
        REG_KSIZE:  ksize_q <= cfg_data_i[2:0];
        default:    coef_q[cfg_idx_i - REG_COEF0] <= cfg_data_i;
      endcase
    end
  end

  imc_front #(.MaxWidth(MaxWidth), .MaxKernel(MaxKernel)) u_front (
    .clk_i, .rst_ni, .restart_i(restart),
    .width_i(width_q), .height_i(height_q), .ksize_i(ksize_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .kind_i(s_axis_tuser), .pix_i(s_axis_tdata),
    .wk_valid_o(fv), .wk_ready_i(fr), .wk_o(fw), .khalf_o(khalf)
  );

  imc_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fw),
    .rd_valid_o(bv), .rd_ready_i(br), .rd_data_o(bw)
  );

  imc_back #(.MaxWidth(MaxWidth), .MaxKernel(MaxKernel), .CoefBits(CoefBits),
             .FracBits(FracBits)) u_back (
    .clk_i, .rst_ni, .khalf_i(khalf), .coef_i(coef_q),
    .wk_valid_i(bv), .wk_ready_o(br), .wk_i(bw),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .pix_o(pix), .border_o(bd), .sat_o(st), .last_o(ls)
  );

  assign m_axis_tdata = pix;
  assign m_axis_tuser = {st, bd};
  assign m_axis_tlast = ls;

`ifndef SYNTHESIS
  // saturation never reported on a copied border pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("saturated border pixel");
  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");
`endif

endmodule

### test/tb.sv
// Testbench for image_convolution_2d: raster frames with random and fixed kernels, checked against
// a behavioral predictor of the window sums, rounding, saturation and border copies.
// Depends on imc_pkg and the image_convolution_2d RTL.
`timescale 1ns / 1ps

module tb;
  import imc_pkg::*;

  typedef struct {
    logic [15:0] pix;
    logic        border;
    logic        sat;
    logic        eof;
  } conv_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [RegIdxBits-1:0] cfg_idx_i = '0;
  logic [RegBits-1:0] cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              m_axis_tlast;

  image_convolution_2d dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [10:0]         reg_width;
  logic [15:0]         reg_height;
  logic [2:0]          reg_ksize;
  logic [59:0]         coef_regs [5];
  logic signed [15:0]  line_mem [4096];
  int                  win [5][5];
  longint              in_row, in_col, out_row, out_col;

  conv_result_t        pending_q [$];
  bit                  idle_on = 1'b0;
  int                  errors = 0;
  int                  n_items = 0;
  int                  n_results = 0;
  int                  n_border = 0;
  int                  n_sat = 0;
  int                  n_frames = 0;

  function automatic void frame_dims(output longint w, output longint hg, output longint k);
    w = (reg_width == 0) ? 1 : ((reg_width > 1024) ? 1024 : reg_width);
    hg = (reg_height == 0) ? 1 : reg_height;
    k = (reg_ksize < 3) ? 3 : ((reg_ksize > 5) ? 5 : reg_ksize);
    if (k % 2 == 0) k = k - 1;
  endfunction

  function automatic void shift_column(int pix, longint col, longint k);
    int v [5];
    v[0] = pix;
    for (int i = 1; i < k; i++) v[i] = line_mem[(i - 1) * 1024 + col];
    for (int i = 0; i + 1 < k; i++) line_mem[i * 1024 + col] = v[i][15:0];
    for (int i = 0; i < k; i++) begin
      for (int j = k - 1; j > 0; j--) win[i][j] = win[i][j - 1];
      win[i][0] = v[i];
    end
  endfunction

  // produce the output for the current out_row / out_col
  function automatic void filter_pixel(longint w, longint hg, longint k);
    longint hw, acc, val;
    logic signed [11:0] cf;
    conv_result_t r;
    hw = (k - 1) / 2;
    r.border = out_row < hw || out_row + hw >= hg || out_col < hw || out_col + hw >= w;
    val = win[hw][hw];
    r.sat = 1'b0;
    if (!r.border) begin
      acc = 0;
      for (int i = 0; i < k; i++)
        for (int j = 0; j < k; j++) begin
          cf = coef_regs[i][j * 12 +: 12];
          acc += longint'(cf) * win[k - 1 - i][k - 1 - j];
        end
      val = (acc + 128) >>> 8;
      if (val > 32767) begin val = 32767; r.sat = 1'b1; end
      if (val < -32768) begin val = -32768; r.sat = 1'b1; end
    end
    r.pix = val[15:0];
    r.eof = (out_row + 1 >= hg) && (out_col + 1 >= w);
    pending_q.push_back(r);
    if (r.eof) begin
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin out_col = 0; out_row++; end
    end
  endfunction

  function automatic void predict_item(kind_e kind, logic [15:0] pix);
    longint w, hg, k, hw, total, n, m, delay;
    frame_dims(w, hg, k);
    hw = (k - 1) / 2;
    total = w * hg;
    n = in_row * w + in_col;
    m = out_row * w + out_col;
    delay = hw * w + hw;
    if (kind == KIND_PIXEL) begin
      if (n >= total) return;
      shift_column(int'($signed(pix)), in_col, k);
      in_col++;
      if (in_col >= w) begin in_col = 0; in_row++; end
      if (n >= m + delay) filter_pixel(w, hg, k);
    end else begin
      if (n < total || m >= total) return;
      shift_column(0, (m + delay) % w, k);
      filter_pixel(w, hg, k);
    end
  endfunction

  function automatic bit drain_pending();
    longint w, hg, k;
    frame_dims(w, hg, k);
    return (in_row * w + in_col >= w * hg) && (out_row * w + out_col < w * hg);
  endfunction

  // output side: random stalls and result check
  always @(posedge clk_i) begin
    conv_result_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        e = pending_q.pop_front();
        n_results++;
        n_border += e.border;
        n_sat += e.sat;
        if (m_axis_tdata !== e.pix || m_axis_tuser[0] !== e.border ||
            m_axis_tuser[1] !== e.sat || m_axis_tlast !== e.eof) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp pix %h brd %b sat %b eof %b, got pix %h brd %b sat %b eof %b",
                     e.pix, e.border, e.sat, e.eof, m_axis_tdata, m_axis_tuser[0],
                     m_axis_tuser[1], m_axis_tlast);
        end
      end
    end
    m_axis_tready <= idle_on ? ($urandom_range(99) >= 23) : 1'b1;
  end

  // one input transfer; valid stays high afterwards until the caller lowers it
  task automatic send_item(kind_e kind, logic [15:0] pix);
    if (idle_on && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(kind, pix);
    n_items++;
  endtask

  task automatic cfg_write(reg_idx_e idx, logic [59:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_WIDTH:  begin reg_width = val[10:0]; in_row = 0; in_col = 0; out_row = 0; out_col = 0; end
      REG_HEIGHT: begin reg_height = val[15:0]; in_row = 0; in_col = 0; out_row = 0; out_col = 0; end
      REG_KSIZE:  begin reg_ksize = val[2:0]; in_row = 0; in_col = 0; out_row = 0; out_col = 0; end
      default:    coef_regs[idx - REG_COEF0] = val;
    endcase
  endtask

  task automatic set_frame(logic [10:0] w, logic [15:0] hg, logic [2:0] k);
    cfg_write(REG_WIDTH, 60'(w));
    cfg_write(REG_HEIGHT, 60'(hg));
    cfg_write(REG_KSIZE, 60'(k));
  endtask

  // mode 0: full random bits, 1: moderate taps, 2: all max, 3: all min
  task automatic set_kernel(int mode);
    logic [59:0] row;
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++)
        case (mode)
          0: row[c * 12 +: 12] = 12'($urandom);
          1: row[c * 12 +: 12] = 12'($urandom_range(600) - 300);
          2: row[c * 12 +: 12] = 12'h7ff;
          default: row[c * 12 +: 12] = 12'h800;
        endcase
      cfg_write(reg_idx_e'(REG_COEF0 + r), row);
    end
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // one frame with early flushes, ignored pixels while draining, then drain
  task automatic run_frame(bit pause_mid);
    longint w, hg, k;
    frame_dims(w, hg, k);
    for (longint i = 0; i < w * hg; i++) begin
      if ($urandom_range(15) == 0) send_item(KIND_FLUSH, 16'($urandom));
      if (pause_mid && i == w * hg / 2) begin
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      send_item(KIND_PIXEL, rand_pixel());
    end
    while (drain_pending()) begin
      if ($urandom_range(7) == 0) send_item(KIND_PIXEL, 16'($urandom));
      else send_item(KIND_FLUSH, 16'($urandom));
    end
    send_item(KIND_FLUSH, 16'($urandom));
    s_axis_tvalid <= 1'b0;
    n_frames++;
  endtask

  task automatic test_tiny_frames();
    set_frame(11'd0, 16'd0, 3'd3);
    run_frame(1'b0);
    set_frame(11'd2, 16'd2, 3'd5);
    run_frame(1'b0);
  endtask

  task automatic test_default_kernel();
    set_frame(11'd4, 16'd3, 3'd3);
    run_frame(1'b0);
  endtask

  task automatic test_saturation();
    set_frame(11'd5, 16'd4, 3'd3);
    set_kernel(2);
    run_frame(1'b1);
    set_kernel(3);
    run_frame(1'b0);
  endtask

  task automatic test_kernel_codes();
    set_kernel(1);
    set_frame(11'd6, 16'd6, 3'd0);
    run_frame(1'b0);
    cfg_write(REG_KSIZE, 60'd4);
    run_frame(1'b0);
    cfg_write(REG_KSIZE, 60'd6);
    run_frame(1'b0);
    cfg_write(REG_KSIZE, 60'd7);
    run_frame(1'b0);
  endtask

  task automatic test_geometry_limits();
    set_kernel(0);
    set_frame(11'd40, 16'd5, 3'd5);
    run_frame(1'b0);
    set_frame(11'd1, 16'd40, 3'd5);
    run_frame(1'b0);
  endtask

  task automatic test_random_frames();
    int stop_at;
    stop_at = n_items + 850;
    while (n_items < stop_at) begin
      idle_on = (n_items > stop_at - 600);
      set_kernel(int'($urandom_range(1)));
      set_frame(11'($urandom_range(12, 1)), 16'($urandom_range(12, 1)), 3'($urandom_range(7)));
      run_frame($urandom_range(9) == 0);
    end
  endtask

  initial begin
    reg_width = 11'd640;
    reg_height = 16'd480;
    reg_ksize = 3'd3;
    foreach (coef_regs[i]) coef_regs[i] = '0;
    coef_regs[2] = 60'd256;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i, j]) win[i][j] = 0;
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_tiny_frames();
    test_default_kernel();
    idle_on = 1'b1;
    test_saturation();
    test_kernel_codes();
    idle_on = 1'b0;
    test_geometry_limits();
    test_random_frames();
    idle_on = 1'b1;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d frames, %0d input transfers, %0d results", n_frames, n_items, n_results);
    $display("results: %0d border copies, %0d saturated sums", n_border, n_sat);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("mismatches: %0d, results missing: %0d", errors, pending_q.size());
      $display("tb: FAIL");
    end
    $finish;
  end

  // run time limit
  initial begin
    #20ms;
    $display("timeout");
    $display("tb: FAIL");
    $finish;
  end

endmodule

### image_convolution_2d.f
hdl/imc_pkg.sv
hdl/imc_front.sv
hdl/imc_queue.sv
hdl/imc_back.sv
hdl/image_convolution_2d.sv
test/tb.sv
